FILE: hw/rtl/ftab_pkg.sv
`timescale 1ns / 1ps

package ftab_pkg;

  // Default table depth
  localparam int FLOW_ENTRIES_DEF = 64;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int PROTO_W  = 8;
  localparam int STAMP_W  = 32;
  localparam int LEN_W    = 16;
  localparam int SLOT_W   = 6;
  localparam int TOTAL_W  = 32;

  // Stored five-tuple: {src, dst, sport, dport, proto}
  localparam int KEY_W  = 2 * ADDR_W + 2 * PORT_W + PROTO_W;
  // Stored statistics: {count, bytes, gaps, last arrival}
  localparam int STAT_W = 3 * TOTAL_W + STAMP_W;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch header, restart scan
    logic scan_issue;  // read key at scan index, advance
    logic take_hit;    // capture matching index as slot
    logic stat_rd;     // read statistics at slot
    logic commit_hit;  // update matched entry, load result
    logic commit_new;  // allocate entry, load result
    logic commit_drop; // load dropped result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic used_zero;   // table empty
    logic full;        // no free entry
    logic cmp_v;       // key read data valid this cycle
    logic match;       // key read data equals header tuple
    logic cmp_last;    // compared entry is the last allocated one
    logic issue_all;   // all allocated keys have been read
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage

FILE: hw/rtl/ftab_ram.sv
`timescale 1ns / 1ps

module ftab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ftab_ctrl.sv
`timescale 1ns / 1ps

module ftab_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ftab_pkg::sts_t sts,
  output ftab_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_STAT_RD,
    S_HIT_UPD,
    S_ALLOC,
    S_DROP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.used_zero ? S_ALLOC : S_SCAN;
        end
      end
      S_SCAN: begin
        // compare of the previous read overlaps the next read
        if (sts.cmp_v && sts.match) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_STAT_RD;
        end else if (sts.cmp_v && sts.cmp_last) begin
          state_nxt = sts.full ? S_DROP : S_ALLOC;
        end else if (!sts.issue_all) begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_STAT_RD: begin
        cmd.stat_rd = 1'b1;
        state_nxt   = S_HIT_UPD;
      end
      S_HIT_UPD: begin
        if (sts.out_free) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (sts.out_free) begin
          cmd.commit_new = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DROP: begin
        if (sts.out_free) begin
          cmd.commit_drop = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/ftab_dp.sv
`timescale 1ns / 1ps

module ftab_dp #(
  parameter int FLOW_ENTRIES = ftab_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ftab_pkg::cmd_t                  cmd,
  output ftab_pkg::sts_t                  sts,
  input  logic [ftab_pkg::ADDR_W-1:0]     in_src_address,
  input  logic [ftab_pkg::ADDR_W-1:0]     in_dst_address,
  input  logic [ftab_pkg::PORT_W-1:0]     in_src_port_num,
  input  logic [ftab_pkg::PORT_W-1:0]     in_dst_port_num,
  input  logic [ftab_pkg::PROTO_W-1:0]    in_proto_num,
  input  logic [ftab_pkg::STAMP_W-1:0]    in_arrival_stamp,
  input  logic [ftab_pkg::LEN_W-1:0]      in_pkt_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ftab_pkg::SLOT_W-1:0]     out_flow_slot,
  output logic                            out_new_flow,
  output logic                            out_dropped,
  output logic [ftab_pkg::TOTAL_W-1:0]    out_packet_total,
  output logic [ftab_pkg::TOTAL_W-1:0]    out_byte_total,
  output logic [ftab_pkg::TOTAL_W-1:0]    out_gap_total
);

  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam int TW    = ftab_pkg::TOTAL_W;

  // Latched header
  logic [ftab_pkg::KEY_W-1:0]   key_r;
  logic [ftab_pkg::STAMP_W-1:0] stamp_r;
  logic [ftab_pkg::LEN_W-1:0]   len_r;

  // Scan and allocation state
  logic [CNT_W-1:0] used_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_v_r;
  logic             issue_all_r;
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] new_idx;

  // Result register
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [ftab_pkg::SLOT_W-1:0] slot_out_r;
  logic                        new_flow_r;
  logic                        dropped_r;
  logic [TW-1:0]               pkt_tot_r;
  logic [TW-1:0]               byte_tot_r;
  logic [TW-1:0]               gap_tot_r;

  // Memories
  logic [ftab_pkg::KEY_W-1:0]  key_rdata;
  logic [ftab_pkg::STAT_W-1:0] stat_rdata;
  logic [ftab_pkg::STAT_W-1:0] stat_wdata;
  logic [IDX_W-1:0]            stat_waddr;

  // Hit update arithmetic
  logic [TW-1:0]               old_cnt;
  logic [TW-1:0]               old_bytes;
  logic [TW-1:0]               old_gaps;
  logic [ftab_pkg::STAMP_W-1:0] old_last;
  logic [TW-1:0]               upd_cnt;
  logic [TW-1:0]               upd_bytes;
  logic [TW-1:0]               upd_gaps;
  logic [TW-1:0]               new_cnt;
  logic [TW-1:0]               new_bytes;

  assign last_idx = IDX_W'(used_r - CNT_W'(1));
  assign new_idx  = IDX_W'(used_r);

  assign {old_cnt, old_bytes, old_gaps, old_last} = stat_rdata;
  assign upd_cnt   = (old_cnt == {TW{1'b1}}) ? old_cnt : old_cnt + TW'(1);
  assign upd_bytes = old_bytes + TW'(len_r);
  assign upd_gaps  = old_gaps + (stamp_r - old_last);
  assign new_cnt   = TW'(1);
  assign new_bytes = TW'(len_r);

  // Statistics write: hit update or fresh entry
  always_comb begin
    if (cmd.commit_hit) begin
      stat_waddr = slot_r;
      stat_wdata = {upd_cnt, upd_bytes, upd_gaps, stamp_r};
    end else begin
      stat_waddr = new_idx;
      stat_wdata = {new_cnt, new_bytes, TW'(0), stamp_r};
    end
  end

  ftab_ram #(
    .WIDTH (ftab_pkg::KEY_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit_new),
    .waddr (new_idx),
    .wdata (key_r),
    .re    (cmd.scan_issue),
    .raddr (scan_idx_r),
    .rdata (key_rdata)
  );

  ftab_ram #(
    .WIDTH (ftab_pkg::STAT_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_stat_ram (
    .clk   (clk),
    .we    (cmd.commit_hit | cmd.commit_new),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .re    (cmd.stat_rd),
    .raddr (slot_r),
    .rdata (stat_rdata)
  );

  // Header latch and scan pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= {in_src_address, in_dst_address, in_src_port_num,
                  in_dst_port_num, in_proto_num};
      stamp_r <= in_arrival_stamp;
      len_r   <= in_pkt_length;
    end
    if (cmd.scan_issue) begin
      cmp_idx_r <= scan_idx_r;
    end
    if (cmd.take_hit) begin
      slot_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      scan_idx_r  <= '0;
      cmp_v_r     <= 1'b0;
      issue_all_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan_issue;
      if (cmd.load) begin
        scan_idx_r  <= '0;
        issue_all_r <= 1'b0;
      end else if (cmd.scan_issue) begin
        scan_idx_r  <= scan_idx_r + IDX_W'(1);
        issue_all_r <= (scan_idx_r == last_idx);
      end
      if (cmd.commit_new) begin
        used_r <= used_r + CNT_W'(1);
      end
    end
  end

  // Result register, freed by an output transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit_hit || cmd.commit_new || cmd.commit_drop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_hit) begin
      slot_out_r <= ftab_pkg::SLOT_W'(slot_r);
      new_flow_r <= 1'b0;
      dropped_r  <= 1'b0;
      pkt_tot_r  <= upd_cnt;
      byte_tot_r <= upd_bytes;
      gap_tot_r  <= upd_gaps;
    end else if (cmd.commit_new) begin
      slot_out_r <= ftab_pkg::SLOT_W'(new_idx);
      new_flow_r <= 1'b1;
      dropped_r  <= 1'b0;
      pkt_tot_r  <= new_cnt;
      byte_tot_r <= new_bytes;
      gap_tot_r  <= '0;
    end else if (cmd.commit_drop) begin
      slot_out_r <= '0;
      new_flow_r <= 1'b0;
      dropped_r  <= 1'b1;
      pkt_tot_r  <= '0;
      byte_tot_r <= '0;
      gap_tot_r  <= '0;
    end
  end

  // Status to controller
  assign sts.used_zero = (used_r == '0);
  assign sts.full      = (used_r == CNT_W'(FLOW_ENTRIES));
  assign sts.cmp_v     = cmp_v_r;
  assign sts.match     = (key_rdata == key_r);
  assign sts.cmp_last  = (cmp_idx_r == last_idx);
  assign sts.issue_all = issue_all_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_flow_slot    = slot_out_r;
  assign out_new_flow     = new_flow_r;
  assign out_dropped      = dropped_r;
  assign out_packet_total = pkt_tot_r;
  assign out_byte_total   = byte_tot_r;
  assign out_gap_total    = gap_tot_r;

endmodule

FILE: hw/rtl/five_tuple_flow_accounting_table.sv
// A hit at entry k ends the scan there, then reads and updates that entry's statistics;
//   a new flow or a drop first scans every allocated entry (an empty table skips the scan).
// Throughput: one header at a time, bounded by the key scan, one stored key
//   read and compared per cycle.
// Reset: synchronous active-low rst_n empties the table (entry count to zero)
//   and clears the controller and result valid; memory contents are not cleared.
`timescale 1ns / 1ps

module five_tuple_flow_accounting_table #(
  parameter int FLOW_ENTRIES = ftab_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ftab_pkg::ADDR_W-1:0]   in_src_address,
  input  logic [ftab_pkg::ADDR_W-1:0]   in_dst_address,
  input  logic [ftab_pkg::PORT_W-1:0]   in_src_port_num,
  input  logic [ftab_pkg::PORT_W-1:0]   in_dst_port_num,
  input  logic [ftab_pkg::PROTO_W-1:0]  in_proto_num,
  input  logic [ftab_pkg::STAMP_W-1:0]  in_arrival_stamp,
  input  logic [ftab_pkg::LEN_W-1:0]    in_pkt_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ftab_pkg::SLOT_W-1:0]   out_flow_slot,
  output logic                          out_new_flow,
  output logic                          out_dropped,
  output logic [ftab_pkg::TOTAL_W-1:0]  out_packet_total,
  output logic [ftab_pkg::TOTAL_W-1:0]  out_byte_total,
  output logic [ftab_pkg::TOTAL_W-1:0]  out_gap_total
);

  ftab_pkg::cmd_t cmd;
  ftab_pkg::sts_t sts;

  ftab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftab_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_src_address   (in_src_address),
    .in_dst_address   (in_dst_address),
    .in_src_port_num  (in_src_port_num),
    .in_dst_port_num  (in_dst_port_num),
    .in_proto_num     (in_proto_num),
    .in_arrival_stamp (in_arrival_stamp),
    .in_pkt_length    (in_pkt_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_flow_slot    (out_flow_slot),
    .out_new_flow     (out_new_flow),
    .out_dropped      (out_dropped),
    .out_packet_total (out_packet_total),
    .out_byte_total   (out_byte_total),
    .out_gap_total    (out_gap_total)
  );

endmodule

FILE: sim/flow_accounting_checker.sv
`timescale 1ns / 1ps

module flow_accounting_checker #(
  parameter int FLOW_ENTRIES = ftab_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ftab_pkg::ADDR_W-1:0]   in_src_address,
  input  logic [ftab_pkg::ADDR_W-1:0]   in_dst_address,
  input  logic [ftab_pkg::PORT_W-1:0]   in_src_port_num,
  input  logic [ftab_pkg::PORT_W-1:0]   in_dst_port_num,
  input  logic [ftab_pkg::PROTO_W-1:0]  in_proto_num,
  input  logic [ftab_pkg::STAMP_W-1:0]  in_arrival_stamp,
  input  logic [ftab_pkg::LEN_W-1:0]    in_pkt_length,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ftab_pkg::SLOT_W-1:0]   out_flow_slot,
  input  logic                          out_new_flow,
  input  logic                          out_dropped,
  input  logic [ftab_pkg::TOTAL_W-1:0]  out_packet_total,
  input  logic [ftab_pkg::TOTAL_W-1:0]  out_byte_total,
  input  logic [ftab_pkg::TOTAL_W-1:0]  out_gap_total,
  output int                            error_count,
  output int                            pending,
  output int                            new_flows,
  output int                            hit_count,
  output int                            drop_count
);
  import ftab_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
    logic [PROTO_W-1:0] proto;
  } flow_key_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               new_flow;
    logic               dropped;
    logic [TOTAL_W-1:0] packets;
    logic [TOTAL_W-1:0] bytes;
    logic [TOTAL_W-1:0] gaps;
  } flow_result_t;

  // Shadow copy of the flow table
  flow_key_t          flow_key   [FLOW_ENTRIES];
  logic [TOTAL_W-1:0] pkt_count  [FLOW_ENTRIES];
  logic [TOTAL_W-1:0] byte_sum   [FLOW_ENTRIES];
  logic [TOTAL_W-1:0] gap_sum    [FLOW_ENTRIES];
  logic [STAMP_W-1:0] last_seen  [FLOW_ENTRIES];
  int                 flows_used;

  // Results still owed by the block, oldest first
  flow_result_t expected_results[$];

  // Look up the header in insertion order and apply the accounting update
  function automatic flow_result_t account_packet(input flow_key_t key,
                                                  input logic [STAMP_W-1:0] stamp,
                                                  input logic [LEN_W-1:0] len);
    flow_result_t r;
    int slot;
    r = '0;
    slot = -1;
    for (int i = 0; i < flows_used; i++) begin
      if (slot < 0 && flow_key[i] == key) slot = i;
    end
    if (slot < 0 && flows_used >= FLOW_ENTRIES) begin
      // table full, no match: fixed dropped result, nothing touched
      r.dropped = 1'b1;
      return r;
    end
    if (slot < 0) begin
      slot = flows_used;
      flows_used++;
      flow_key[slot]  = key;
      pkt_count[slot] = 1;
      byte_sum[slot]  = TOTAL_W'(len);
      gap_sum[slot]   = '0;
      last_seen[slot] = stamp;
      r.new_flow      = 1'b1;
    end else begin
      byte_sum[slot] = byte_sum[slot] + TOTAL_W'(len);
      if (pkt_count[slot] != '1) pkt_count[slot] = pkt_count[slot] + 1'b1;
      // gap is mod 2^32, so a backwards arrival adds a wrapped value
      gap_sum[slot]   = gap_sum[slot] + (stamp - last_seen[slot]);
      last_seen[slot] = stamp;
    end
    r.slot    = slot[SLOT_W-1:0];
    r.packets = pkt_count[slot];
    r.bytes   = byte_sum[slot];
    r.gaps    = gap_sum[slot];
    return r;
  endfunction

  // Watch both channels; results are retired before new headers are predicted
  always @(posedge clk) begin
    flow_result_t want;
    flow_result_t got;
    flow_key_t    key;
    if (!rst_n) begin
      flows_used = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.slot     = out_flow_slot;
        got.new_flow = out_new_flow;
        got.dropped  = out_dropped;
        got.packets  = out_packet_total;
        got.bytes    = out_byte_total;
        got.gaps     = out_gap_total;
        if (expected_results.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: unexpected result transaction slot=%0d new=%0b drop=%0b",
                     $realtime, got.slot, got.new_flow, got.dropped);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.slot !== want.slot || got.new_flow !== want.new_flow ||
              got.dropped !== want.dropped || got.packets !== want.packets ||
              got.bytes !== want.bytes || got.gaps !== want.gaps) begin
            if (error_count < MAX_REPORTS) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected slot=%0d new=%0b drop=%0b pkts=%0d bytes=%0d gaps=%0d",
                       want.slot, want.new_flow, want.dropped, want.packets,
                       want.bytes, want.gaps);
              $display("  actual   slot=%0d new=%0b drop=%0b pkts=%0d bytes=%0d gaps=%0d",
                       got.slot, got.new_flow, got.dropped, got.packets,
                       got.bytes, got.gaps);
            end
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        key.src   = in_src_address;
        key.dst   = in_dst_address;
        key.sport = in_src_port_num;
        key.dport = in_dst_port_num;
        key.proto = in_proto_num;
        want = account_packet(key, in_arrival_stamp, in_pkt_length);
        expected_results.insert(expected_results.size(), want);
        if (want.dropped) drop_count++;
        else if (want.new_flow) new_flows++;
        else hit_count++;
      end
      pending <= expected_results.size();
    end
  end

endmodule

FILE: sim/five_tuple_flow_accounting_table_tb.sv
`timescale 1ns / 1ps

module five_tuple_flow_accounting_table_tb;
  import ftab_pkg::*;

  localparam int TABLE_DEPTH = FLOW_ENTRIES_DEF;
  localparam int NUM_RANDOM  = 1780;
  localparam int MAX_IDLE    = 11;

  typedef struct packed {
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
    logic [PROTO_W-1:0] proto;
  } flow_key_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADDR_W-1:0]   in_src_address = '0;
  logic [ADDR_W-1:0]   in_dst_address = '0;
  logic [PORT_W-1:0]   in_src_port_num = '0;
  logic [PORT_W-1:0]   in_dst_port_num = '0;
  logic [PROTO_W-1:0]  in_proto_num = '0;
  logic [STAMP_W-1:0]  in_arrival_stamp = '0;
  logic [LEN_W-1:0]    in_pkt_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SLOT_W-1:0]   out_flow_slot;
  logic                out_new_flow;
  logic                out_dropped;
  logic [TOTAL_W-1:0]  out_packet_total;
  logic [TOTAL_W-1:0]  out_byte_total;
  logic [TOTAL_W-1:0]  out_gap_total;

  int error_count;
  int pending;
  int new_flows;
  int hit_count;
  int drop_count;

  // Stretches with no idling on either side
  bit steady = 1'b0;

  // Tuples that have been offered as flows, for reuse
  flow_key_t          known_flows[$];
  logic [STAMP_W-1:0] now = '0;

  five_tuple_flow_accounting_table DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_address   (in_src_address),
    .in_dst_address   (in_dst_address),
    .in_src_port_num  (in_src_port_num),
    .in_dst_port_num  (in_dst_port_num),
    .in_proto_num     (in_proto_num),
    .in_arrival_stamp (in_arrival_stamp),
    .in_pkt_length    (in_pkt_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_flow_slot    (out_flow_slot),
    .out_new_flow     (out_new_flow),
    .out_dropped      (out_dropped),
    .out_packet_total (out_packet_total),
    .out_byte_total   (out_byte_total),
    .out_gap_total    (out_gap_total)
  );

  flow_accounting_checker #(
    .FLOW_ENTRIES (TABLE_DEPTH)
  ) u_accounting_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_address   (in_src_address),
    .in_dst_address   (in_dst_address),
    .in_src_port_num  (in_src_port_num),
    .in_dst_port_num  (in_dst_port_num),
    .in_proto_num     (in_proto_num),
    .in_arrival_stamp (in_arrival_stamp),
    .in_pkt_length    (in_pkt_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_flow_slot    (out_flow_slot),
    .out_new_flow     (out_new_flow),
    .out_dropped      (out_dropped),
    .out_packet_total (out_packet_total),
    .out_byte_total   (out_byte_total),
    .out_gap_total    (out_gap_total),
    .error_count      (error_count),
    .pending          (pending),
    .new_flows        (new_flows),
    .hit_count        (hit_count),
    .drop_count       (drop_count)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("five_tuple_flow_accounting_table_tb: FAIL");
    $finish;
  end

  // Offer one header after a random idle gap and hold it until accepted
  task automatic send_header(input flow_key_t key, input logic [STAMP_W-1:0] stamp,
                             input logic [LEN_W-1:0] len);
    int gap;
    if ($urandom_range(0, 79) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_src_address   <= key.src;
    in_dst_address   <= key.dst;
    in_src_port_num  <= key.sport;
    in_dst_port_num  <= key.dport;
    in_proto_num     <= key.proto;
    in_arrival_stamp <= stamp;
    in_pkt_length    <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic flow_key_t random_key();
    flow_key_t k;
    k.src   = $urandom;
    k.dst   = $urandom;
    k.sport = $urandom_range(0, 65535);
    k.dport = $urandom_range(0, 65535);
    k.proto = $urandom_range(0, 255);
    return k;
  endfunction

  // Each field at zero, all ones, or random
  function automatic flow_key_t corner_key();
    flow_key_t k;
    k = random_key();
    case ($urandom_range(0, 2))
      0: k.src = '0;
      1: k.src = '1;
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: k.dst = '0;
      1: k.dst = '1;
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: k.sport = '0;
      1: k.sport = '1;
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: k.dport = '0;
      1: k.dport = '1;
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: k.proto = '0;
      1: k.proto = '1;
      default: ;
    endcase
    return k;
  endfunction

  // Result side: random stall per transaction
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    flow_key_t          k;
    flow_key_t          zero_key;
    flow_key_t          ones_key;
    logic [STAMP_W-1:0] stamp;
    logic [LEN_W-1:0]   len;
    int                 pick;
    int                 bitpos;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme tuples, stamps and lengths on an empty table
    zero_key = '0;
    ones_key = '1;
    known_flows.insert(known_flows.size(), zero_key);
    known_flows.insert(known_flows.size(), ones_key);
    send_header(zero_key, '0, '0);
    send_header(ones_key, '1, '1);
    send_header(zero_key, 32'd5, '1);
    // arrivals going backwards give wrapped gaps
    send_header(ones_key, 32'd3, '1);
    send_header(ones_key, '0, 16'd1);

    // tuples one field away from the zero or all-ones tuple must not match it
    k = zero_key; k.src[ADDR_W-1] = 1'b1;
    known_flows.insert(known_flows.size(), k); send_header(k, 32'd10, 16'd100);
    k = zero_key; k.dst[ADDR_W-1] = 1'b1;
    known_flows.insert(known_flows.size(), k); send_header(k, 32'd11, 16'd101);
    k = zero_key; k.sport[PORT_W-1] = 1'b1;
    known_flows.insert(known_flows.size(), k); send_header(k, 32'd12, 16'd102);
    k = zero_key; k.dport[PORT_W-1] = 1'b1;
    known_flows.insert(known_flows.size(), k); send_header(k, 32'd13, 16'd103);
    k = zero_key; k.proto[PROTO_W-1] = 1'b1;
    known_flows.insert(known_flows.size(), k); send_header(k, 32'd14, 16'd104);
    k = ones_key; k.proto[0] = 1'b0;
    known_flows.insert(known_flows.size(), k); send_header(k, 32'd15, 16'd105);

    // hit on the most recently allocated entry, then a wrapping gap
    send_header(k, '1, '1);
    send_header(k, 32'd1, '0);
    send_header(zero_key, '1, 16'd1);

    // Random: mostly repeats of known flows, some new, near misses and noise
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      // make sure the table fills during the second half
      if (known_flows.size() < TABLE_DEPTH && i >= NUM_RANDOM / 2) pick = 0;
      if (pick < 7) begin
        k = random_key();
        if (known_flows.size() < TABLE_DEPTH) known_flows.insert(known_flows.size(), k);
      end else if (pick < 11) begin
        k = known_flows[$urandom_range(0, known_flows.size() - 1)];
        bitpos = $urandom_range(0, $bits(flow_key_t) - 1);
        k[bitpos] = ~k[bitpos];
        if (known_flows.size() < TABLE_DEPTH) known_flows.insert(known_flows.size(), k);
      end else if (pick < 14) begin
        k = corner_key();
      end else begin
        k = known_flows[$urandom_range(0, known_flows.size() - 1)];
      end

      if ($urandom_range(0, 4) == 0) begin
        stamp = $urandom;
      end else begin
        now   = now + $urandom_range(0, 4000);
        stamp = now;
      end

      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = '1;
        default: len = $urandom_range(0, 65535);
      endcase

      send_header(k, stamp, len);
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);

    $display("Covered %0d headers: %0d new flows, %0d hits, %0d dropped on a full table",
             new_flows + hit_count + drop_count, new_flows, hit_count, drop_count);
    $display("Mismatches or stray results: %0d, results still owed: %0d",
             error_count, pending);
    if (error_count == 0 && pending == 0) begin
      $display("five_tuple_flow_accounting_table_tb: PASS");
    end else begin
      $display("five_tuple_flow_accounting_table_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: five_tuple_flow_accounting_table.f
hw/rtl/ftab_pkg.sv
hw/rtl/ftab_ram.sv
hw/rtl/ftab_ctrl.sv
hw/rtl/ftab_dp.sv
hw/rtl/five_tuple_flow_accounting_table.sv
sim/flow_accounting_checker.sv
sim/five_tuple_flow_accounting_table_tb.sv
